// ===== rtl/i2c_master_transfer_sequencer_top_macros.svh =====
// assertion helpers shared by the sequencer files
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define I2CMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

   // field widths
   localparam int unsigned CNT_W      = 9;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned OUTCOME_W  = 2;
   localparam int unsigned ADDR7_W    = 7;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned DEF_BUFFER_DEPTH = 256;

   // request operations
   localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

   // transfer kinds
   localparam logic [KIND_W-1:0] KIND_READ       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE_READ = 2'd2;

   // outcomes
   localparam logic [OUTCOME_W-1:0] OUTCOME_NONE    = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FULL    = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_PARTIAL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_DIVIDER = 1'd1;

   // bus status codes
   localparam logic [BYTE_W-1:0] ST_START         = 8'h08;
   localparam logic [BYTE_W-1:0] ST_RESTART       = 8'h10;
   localparam logic [BYTE_W-1:0] ST_MT_SLA_ACK    = 8'h18;
   localparam logic [BYTE_W-1:0] ST_MT_SLA_NACK   = 8'h20;
   localparam logic [BYTE_W-1:0] ST_MT_DATA_ACK   = 8'h28;
   localparam logic [BYTE_W-1:0] ST_MT_DATA_NACK  = 8'h30;
   localparam logic [BYTE_W-1:0] ST_ARB_LOST      = 8'h38;
   localparam logic [BYTE_W-1:0] ST_MR_SLA_ACK    = 8'h40;
   localparam logic [BYTE_W-1:0] ST_MR_SLA_NACK   = 8'h48;
   localparam logic [BYTE_W-1:0] ST_MR_DATA_ACK   = 8'h50;
   localparam logic [BYTE_W-1:0] ST_MR_DATA_NACK  = 8'h58;
   localparam logic [BYTE_W-1:0] ADDR_MASK        = 8'hFE;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [KIND_W-1:0] transfer_kind;
      logic [CNT_W-1:0]  write_length;
      logic [CNT_W-1:0]  read_length;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] status_code;
   } req_type;

   typedef struct packed {
      logic                 tx_valid;
      logic [BYTE_W-1:0]    tx_byte;
      logic                 set_start;
      logic                 clear_start;
      logic                 set_stop;
      logic                 set_ack;
      logic                 clear_ack;
      logic                 rx_valid;
      logic [BYTE_W-1:0]    rx_byte;
      logic                 done_res;
      logic [OUTCOME_W-1:0] outcome;
      logic [CNT_W-1:0]     bytes_done;
   } rsp_type;

   // full when equal, partial when some but fewer, otherwise none
   function automatic logic [OUTCOME_W-1:0] compare_counts(
      input logic [CNT_W-1:0] done_cnt,
      input logic [CNT_W-1:0] req_cnt
   );
      logic [OUTCOME_W-1:0] res;
      res = OUTCOME_NONE;
      if (done_cnt == req_cnt) begin
         res = OUTCOME_FULL;
      end else if (done_cnt != '0 && done_cnt < req_cnt) begin
         res = OUTCOME_PARTIAL;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cms_ifs.sv =====
`default_nettype none

// request channel
interface i2cms_req_if;
   logic                   valid;
   logic                   ready;
   i2cms_pkg::req_type     data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// result channel
interface i2cms_rsp_if;
   logic                   valid;
   logic                   ready;
   i2cms_pkg::rsp_type     data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cms_ram.sv =====
`default_nettype none

module i2cms_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/i2cms_seq.sv =====
`default_nettype none

module i2cms_seq #(
   parameter int unsigned BUFFER_DEPTH = 256,
   parameter int unsigned AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  i2cms_pkg::req_type                  item,
   input  logic [i2cms_pkg::ADDR7_W-1:0]       slave_address,
   input  logic [i2cms_pkg::BYTE_W-1:0]        ram_rd_data,
   output logic                                ram_wr_en,
   output logic [AW-1:0]                       ram_wr_addr,
   output logic [i2cms_pkg::BYTE_W-1:0]        ram_wr_data,
   output logic [AW-1:0]                       ram_rd_addr,
   output i2cms_pkg::rsp_type                  result
);
   import i2cms_pkg::*;

   localparam int unsigned LPW = $clog2(BUFFER_DEPTH + 1);

   logic [LPW-1:0]   load_ptr_ff,   load_ptr_in;
   logic             active_ff,     active_in;
   logic             read_phase_ff, read_phase_in;
   logic             chain_ff,      chain_in;
   logic [CNT_W-1:0] wreq_ff,       wreq_in;
   logic [CNT_W-1:0] wsent_ff,      wsent_in;
   logic [CNT_W-1:0] rreq_ff,       rreq_in;
   logic [CNT_W-1:0] rrecv_ff,      rrecv_in;
   logic             byp_vld_ff,    byp_vld_in;
   logic [BYTE_W-1:0] byp_data_ff,  byp_data_in;

   logic              load_ok;
   logic              stop;
   logic [BYTE_W-1:0] store_byte;
   logic [CNT_W-1:0]  rleft;
   logic [CNT_W-1:0]  wlen_sat;
   rsp_type           res;

   // write byte for the current write pointer, with same-cycle write forwarding
   assign store_byte = byp_vld_ff ? byp_data_ff : ram_rd_data;
   assign load_ok    = (load_ptr_ff < LPW'(BUFFER_DEPTH));
   assign rleft      = rreq_ff - rrecv_ff;
   assign wlen_sat   = (32'(item.write_length) > BUFFER_DEPTH) ?
                       CNT_W'(BUFFER_DEPTH) : item.write_length;

   // decision for one request
   always_comb begin
      load_ptr_in   = load_ptr_ff;
      active_in     = active_ff;
      read_phase_in = read_phase_ff;
      chain_in      = chain_ff;
      wreq_in       = wreq_ff;
      wsent_in      = wsent_ff;
      rreq_in       = rreq_ff;
      rrecv_in      = rrecv_ff;
      stop          = 1'b0;
      res           = '0;

      case (item.operation)
         OP_BEGIN: begin
            if (!active_ff && item.transfer_kind <= KIND_WRITE_READ) begin
               active_in     = 1'b1;
               read_phase_in = (item.transfer_kind == KIND_READ);
               chain_in      = (item.transfer_kind == KIND_WRITE_READ);
               wreq_in       = (item.transfer_kind == KIND_READ) ? '0 : wlen_sat;
               rreq_in       = (item.transfer_kind == KIND_WRITE) ? '0 : item.read_length;
               wsent_in      = '0;
               rrecv_in      = '0;
               res.set_start = 1'b1;
            end
         end
         OP_LOAD: begin
            if (load_ok) begin
               load_ptr_in = load_ptr_ff + LPW'(1);
            end
         end
         OP_EVENT: begin
            if (active_ff) begin
               case (item.status_code) inside
                  ST_START, ST_RESTART: begin
                     res.tx_valid    = 1'b1;
                     res.tx_byte     = ({slave_address, 1'b0} & ADDR_MASK) |
                                       {7'd0, read_phase_ff};
                     res.clear_start = 1'b1;
                  end
                  ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                     if (read_phase_ff) begin
                        stop = 1'b1;
                     end else if (wsent_ff >= wreq_ff) begin
                        if (chain_ff) begin
                           // repeated start into the read phase
                           chain_in      = 1'b0;
                           read_phase_in = 1'b1;
                           rrecv_in      = '0;
                           res.set_start = 1'b1;
                        end else begin
                           stop = 1'b1;
                        end
                     end else begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = store_byte;
                        wsent_in     = wsent_ff + CNT_W'(1);
                     end
                  end
                  ST_MR_SLA_ACK: begin
                     if (!read_phase_ff || rrecv_ff >= rreq_ff) begin
                        stop = 1'b1;
                     end else if (rleft == CNT_W'(1)) begin
                        res.clear_ack = 1'b1;
                     end else begin
                        res.set_ack = 1'b1;
                     end
                  end
                  ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
                     if (!read_phase_ff || rrecv_ff >= rreq_ff) begin
                        stop = 1'b1;
                     end else begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = item.data_byte;
                        rrecv_in     = rrecv_ff + CNT_W'(1);
                        // one byte left: do not acknowledge it; none left: stop
                        if (rleft == CNT_W'(2)) begin
                           res.clear_ack = 1'b1;
                        end
                        if (rleft == CNT_W'(1)) begin
                           stop = 1'b1;
                        end
                     end
                  end
                  default: begin
                     stop = 1'b1;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      // stop condition and outcome
      if (stop) begin
         res.set_stop    = 1'b1;
         res.clear_start = 1'b1;
         res.clear_ack   = 1'b1;
         res.done_res    = 1'b1;
         if (read_phase_ff) begin
            res.outcome = compare_counts(rrecv_in, rreq_ff);
         end else if (chain_ff) begin
            res.outcome = (wsent_ff != wreq_ff) ? OUTCOME_PARTIAL :
                          compare_counts(rrecv_in, rreq_ff);
         end else begin
            res.outcome = compare_counts(wsent_ff, wreq_ff);
         end
         active_in   = 1'b0;
         chain_in    = 1'b0;
         load_ptr_in = '0;
      end

      res.bytes_done = read_phase_in ? rrecv_in : wsent_in;
   end

   assign result = res;

   // write store ports: read ahead at the pointer the next request will use
   assign ram_wr_en   = advance && (item.operation == OP_LOAD) && load_ok;
   assign ram_wr_addr = AW'(load_ptr_ff);
   assign ram_wr_data = item.data_byte;
   assign ram_rd_addr = advance ? AW'(wsent_in) : AW'(wsent_ff);

   assign byp_vld_in  = ram_wr_en && (ram_wr_addr == ram_rd_addr);
   assign byp_data_in = ram_wr_data;

   // transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff   <= '0;
         active_ff     <= 1'b0;
         read_phase_ff <= 1'b0;
         chain_ff      <= 1'b0;
         wreq_ff       <= '0;
         wsent_ff      <= '0;
         rreq_ff       <= '0;
         rrecv_ff      <= '0;
         byp_vld_ff    <= 1'b0;
      end else begin
         if (advance) begin
            load_ptr_ff   <= load_ptr_in;
            active_ff     <= active_in;
            read_phase_ff <= read_phase_in;
            chain_ff      <= chain_in;
            wreq_ff       <= wreq_in;
            wsent_ff      <= wsent_in;
            rreq_ff       <= rreq_in;
            rrecv_ff      <= rrecv_in;
         end
         byp_vld_ff <= byp_vld_in;
      end
   end

   // forwarded write data
   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
   end

`include "i2c_master_transfer_sequencer_top_macros.svh"

   `I2CMS_ASSERT_NEXT(a_stop_goes_idle, clock, reset, advance && result.done_res, !active_ff, "transfer still active after stop")
   `I2CMS_ASSERT_SAME(a_rx_in_read_phase, clock, reset, advance && result.rx_valid, read_phase_ff && active_ff, "byte delivered outside read phase")
   `I2CMS_ASSERT_SAME(a_load_ptr_range, clock, reset, 1'b1, load_ptr_ff <= LPW'(BUFFER_DEPTH), "load pointer beyond write store")

endmodule

`default_nettype wire

// ===== rtl/i2c_master_transfer_sequencer_top.sv =====
// a request waits in the input register until the response register is free
// throughput: one request per cycle while the response slot is free; the single
//   decision stage between the input and response registers sets this figure
// the write store read is issued ahead, at the pointer the next request uses
// reset: synchronous, active high; clears the transfer state, counters, slave address
//   and both channel valid flags; the write store is not cleared

`default_nettype none

module i2c_master_transfer_sequencer_top #(
   parameter int unsigned BUFFER_DEPTH = i2cms_pkg::DEF_BUFFER_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   i2cms_req_if.sink                              req_if,
   i2cms_rsp_if.source                            rsp_if,
   input  logic                                   csr_we,
   input  logic [i2cms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import i2cms_pkg::*;

   localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic               in_vld_ff,    in_vld_in;
   req_type            in_data_ff,   in_data_in;
   logic               rsp_vld_ff,   rsp_vld_in;
   rsp_type            rsp_data_ff,  rsp_data_in;
   logic [ADDR7_W-1:0] slave_addr_ff, slave_addr_in;

   logic               advance;
   rsp_type            result;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [BYTE_W-1:0]  ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [BYTE_W-1:0]  ram_rd_data;

   // handshake: the held request moves on whenever the response slot is free
   assign advance      = in_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !in_vld_ff || advance;

   assign in_vld_in   = req_if.ready ? req_if.valid : in_vld_ff;
   assign in_data_in  = (req_if.valid && req_if.ready) ? req_if.data : in_data_ff;
   assign rsp_vld_in  = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_vld_ff);
   assign rsp_data_in = advance ? result : rsp_data_ff;

   // slave address register; the divider write is taken but drives no response field
   assign slave_addr_in = (csr_we && csr_index == CSR_SLAVE_ADDRESS) ?
                          csr_wdata[ADDR7_W-1:0] : slave_addr_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         slave_addr_ff <= '0;
      end else begin
         in_vld_ff     <= in_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         slave_addr_ff <= slave_addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.data  = rsp_data_ff;

   // decision logic and transfer state
   i2cms_seq #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .AW           (AW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (in_data_ff),
      .slave_address (slave_addr_ff),
      .ram_rd_data   (ram_rd_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .result        (result)
   );

   // write byte store
   i2cms_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`include "i2c_master_transfer_sequencer_top_macros.svh"

   `I2CMS_ASSERT_SAME(a_outcome_only_when_done, clock, reset, rsp_vld_ff && !rsp_data_ff.done_res, rsp_data_ff.outcome == OUTCOME_NONE, "outcome set without stop")
   `I2CMS_ASSERT_NEXT(a_held_request_kept, clock, reset, in_vld_ff && !advance, in_vld_ff, "held request dropped")
   `I2CMS_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_vld_ff, "processed request gave no response")

endmodule

`default_nettype wire
